@@ rtl/ocp_pkg.sv @@
// Shared types and constants for the ordered crossover pair block.
// Used by the channel interfaces, the parent store RAM users and the top level.
package ocp_pkg;

	localparam int MAX_CITIES = 32;
	localparam int CITY_W = 5;
	localparam int CITY_SPAN = 1 << CITY_W;
	localparam int RANGE_W = 6;
	localparam int POS_W = 5;
	localparam int IDX_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int CNT_W = $clog2(MAX_CITIES + 1);
	localparam int CMP_W = (CNT_W > RANGE_W) ? CNT_W : RANGE_W;

	typedef struct packed {
		logic [CITY_W-1:0]  first_parent_city;
		logic [CITY_W-1:0]  second_parent_city;
		logic [RANGE_W-1:0] range_begin;
		logic [RANGE_W-1:0] range_end;
		logic               last_element;
	} in_word_t;

	typedef struct packed {
		logic [CITY_W-1:0] child_a_city;
		logic [CITY_W-1:0] child_b_city;
		logic [POS_W-1:0]  position;
		logic              parents_mismatch;
		logic              last_result;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_START,
		ST_MARK,
		ST_EMIT
	} state_t;

endpackage

@@ rtl/ocp_if.sv @@
// Valid/ready channel interfaces for the parent pair input and the child output.
// Depends on ocp_pkg for the word types.
interface ocp_in_if import ocp_pkg::*;;
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ocp_out_if import ocp_pkg::*;;
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ocp_ram.sv @@
// Generic synchronous RAM with one write port and two registered read ports.
// Standalone; no package dependency.
module ocp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

@@ rtl/ordered_crossover_pair.sv @@
// Top level of the ordered crossover pair block: parent stores, cut marking and child emission.
// Depends on ocp_pkg, the ocp_in_if / ocp_out_if interfaces and ocp_ram.
//
//   channel    dir   handshake      word
//   parents    in    valid/ready    one position pair, cut points, last flag
//   children   out   valid/ready    one position of both children
//
// Loading accepts one pair per cycle. The last pair starts a crossover of a start step, a
// marking step for each position inside the cut to mark the cut cities, and an emission step
// for each position; a fill position also waits for each city skipped by whichever walk
// skips more cities there, since each walk reads its store through a single RAM port.
// Parents are not accepted during the crossover.
// Reset clears the control state and the membership bitmaps; the stores need no clearing.
// A stalled output holds its word and the emission waits for it.
module ordered_crossover_pair import ocp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ocp_in_if.sink           parents,
	ocp_out_if.source        children
);

	state_t                state_q, state_d;
	logic [CNT_W-1:0]      cnt_q, n_q, i_q, i_d, fa_q, fa_d, fb_q, fb_d;
	logic [CMP_W-1:0]      b_q, e_q;
	logic [CITY_SPAN-1:0]  seg_a_q, seg_b_q;
	logic                  mis_q;
	logic                  out_valid_q;
	out_word_t             out_data_q;

	logic                  load_acc, store, out_free, emit;
	logic [CNT_W-1:0]      n_new, i_inc;
	logic [CMP_W-1:0]      e_clamp, range_end_ext, n_new_ext;
	logic                  in_seg, a_exh, b_exh, a_skip, b_skip, a_ok, b_ok, mis_now, last_pos;
	logic [CITY_W-1:0]     a_pos, b_pos, a_fill, b_fill, ca, cb;

	// Each store serves a position read and the other child's fill walk.
	ocp_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_store_a (
		.clk    (clk),
		.we     (store),
		.waddr  (cnt_q[IDX_W-1:0]),
		.wdata  (parents.data.first_parent_city),
		.raddr0 (i_d[IDX_W-1:0]),
		.rdata0 (a_pos),
		.raddr1 (fb_d[IDX_W-1:0]),
		.rdata1 (a_fill)
	);

	ocp_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_store_b (
		.clk    (clk),
		.we     (store),
		.waddr  (cnt_q[IDX_W-1:0]),
		.wdata  (parents.data.second_parent_city),
		.raddr0 (i_d[IDX_W-1:0]),
		.rdata0 (b_pos),
		.raddr1 (fa_d[IDX_W-1:0]),
		.rdata1 (b_fill)
	);

	assign parents.ready = (state_q == ST_LOAD);
	assign load_acc = parents.valid && parents.ready;
	assign store = load_acc && (cnt_q < CNT_W'(MAX_CITIES));
	assign n_new = store ? CNT_W'(cnt_q + 1'b1) : cnt_q;
	assign range_end_ext = CMP_W'(parents.data.range_end);
	assign n_new_ext = CMP_W'(n_new);
	assign e_clamp = (range_end_ext > n_new_ext) ? n_new_ext : range_end_ext;

	assign out_free = !out_valid_q || children.ready;
	assign i_inc = CNT_W'(i_q + 1'b1);

	// Each fill walk reads the entry its pointer holds; a marked city is skipped.
	assign in_seg = (CMP_W'(i_q) >= b_q) && (CMP_W'(i_q) < e_q);
	assign a_exh = (fa_q >= n_q);
	assign b_exh = (fb_q >= n_q);
	assign a_skip = !a_exh && seg_a_q[b_fill];
	assign b_skip = !b_exh && seg_b_q[a_fill];
	assign a_ok = in_seg || !a_skip;
	assign b_ok = in_seg || !b_skip;
	assign ca = in_seg ? a_pos : (a_exh ? '0 : b_fill);
	assign cb = in_seg ? b_pos : (b_exh ? '0 : a_fill);
	assign mis_now = mis_q || (!in_seg && (a_exh || b_exh));
	assign last_pos = (i_inc == n_q);
	assign emit = (state_q == ST_EMIT) && a_ok && b_ok && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (load_acc && parents.data.last_element) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = (b_q < e_q) ? ST_MARK : ST_EMIT;
			end
			ST_MARK: begin
				if (CMP_W'(i_inc) == e_q) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit && last_pos) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		i_d = i_q;
		fa_d = fa_q;
		fb_d = fb_q;
		case (state_q)
			ST_LOAD: begin
			end
			ST_START: begin
				i_d = (b_q < e_q) ? CNT_W'(b_q) : '0;
				fa_d = '0;
				fb_d = '0;
			end
			ST_MARK: begin
				i_d = (CMP_W'(i_inc) == e_q) ? '0 : i_inc;
			end
			ST_EMIT: begin
				if (emit) begin
					i_d = i_inc;
				end
				if (!in_seg) begin
					if (a_skip || (emit && !a_exh)) begin
						fa_d = CNT_W'(fa_q + 1'b1);
					end
					if (b_skip || (emit && !b_exh)) begin
						fb_d = CNT_W'(fb_q + 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			fa_q <= '0;
			fb_q <= '0;
			b_q <= '0;
			e_q <= '0;
			seg_a_q <= '0;
			seg_b_q <= '0;
			mis_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			fa_q <= fa_d;
			fb_q <= fb_d;
			if (store) begin
				cnt_q <= n_new;
			end
			if (load_acc && parents.data.last_element) begin
				n_q <= n_new;
				b_q <= CMP_W'(parents.data.range_begin);
				e_q <= e_clamp;
			end
			if (state_q == ST_START) begin
				cnt_q <= '0;
				seg_a_q <= '0;
				seg_b_q <= '0;
				mis_q <= 1'b0;
			end
			if (state_q == ST_MARK) begin
				seg_a_q[a_pos] <= 1'b1;
				seg_b_q[b_pos] <= 1'b1;
			end
			if (emit) begin
				mis_q <= mis_now;
				out_valid_q <= 1'b1;
			end else if (children.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.child_a_city <= ca;
			out_data_q.child_b_city <= cb;
			out_data_q.position <= POS_W'(i_q);
			out_data_q.parents_mismatch <= mis_now;
			out_data_q.last_result <= last_pos;
		end
	end

	assign children.valid = out_valid_q;
	assign children.data = out_data_q;

endmodule

@@ tb/sv/ocp_child_compare.sv @@
// Prediction and comparison of the child words of the ordered crossover pair block.
// Watches both channels; depends on ocp_pkg and the ocp_in_if / ocp_out_if interfaces.
module ocp_child_compare import ocp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ocp_in_if    parents,
	ocp_out_if   children,
	output int   mismatches,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CITY_W-1:0] tour_a_held [MAX_CITIES];
	logic [CITY_W-1:0] tour_b_held [MAX_CITIES];
	int                pairs_held;
	out_word_t         children_due [$];

	initial begin
		mismatches = 0;
		pending = 0;
		pairs_held = 0;
	end

	// Builds both children of the held parents for the cut [cut_lo, cut_hi).
	task automatic predict_children(input int cut_lo, input int cut_hi);
		bit        cut_a_has [CITY_SPAN];
		bit        cut_b_has [CITY_SPAN];
		int        walk_a;
		int        walk_b;
		bit        ran_dry;
		out_word_t w;
		if (cut_hi > pairs_held)
			cut_hi = pairs_held;
		for (int c = 0; c < CITY_SPAN; c++) begin
			cut_a_has[c] = 1'b0;
			cut_b_has[c] = 1'b0;
		end
		for (int i = cut_lo; i < cut_hi; i++) begin
			cut_a_has[tour_a_held[i]] = 1'b1;
			cut_b_has[tour_b_held[i]] = 1'b1;
		end
		walk_a = 0;
		walk_b = 0;
		ran_dry = 1'b0;
		for (int i = 0; i < pairs_held; i++) begin
			if (i >= cut_lo && i < cut_hi) begin
				w.child_a_city = tour_a_held[i];
				w.child_b_city = tour_b_held[i];
			end else begin
				while (walk_a < pairs_held && cut_a_has[tour_b_held[walk_a]])
					walk_a++;
				if (walk_a >= pairs_held) begin
					w.child_a_city = '0;
					ran_dry = 1'b1;
				end else begin
					w.child_a_city = tour_b_held[walk_a];
					walk_a++;
				end
				while (walk_b < pairs_held && cut_b_has[tour_a_held[walk_b]])
					walk_b++;
				if (walk_b >= pairs_held) begin
					w.child_b_city = '0;
					ran_dry = 1'b1;
				end else begin
					w.child_b_city = tour_a_held[walk_b];
					walk_b++;
				end
			end
			w.position = POS_W'(i);
			w.parents_mismatch = ran_dry;
			w.last_result = (i + 1 == pairs_held);
			children_due.push_back(w);
		end
		pairs_held = 0;
	endtask

	function automatic int field_differs(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t got;
		in_word_t  pair;
		if (!arst_n) begin
			pairs_held = 0;
			children_due.delete();
		end else begin
			if (children.valid && children.ready) begin
				got = children.data;
				if (children_due.size() == 0) begin
					$display("%0t: expected no word, actual %h", $time, got);
					mismatches++;
				end else begin
					want = children_due.pop_front();
					mismatches += field_differs("child_a_city", int'(want.child_a_city),
						int'(got.child_a_city));
					mismatches += field_differs("child_b_city", int'(want.child_b_city),
						int'(got.child_b_city));
					mismatches += field_differs("position", int'(want.position),
						int'(got.position));
					mismatches += field_differs("parents_mismatch",
						int'(want.parents_mismatch), int'(got.parents_mismatch));
					mismatches += field_differs("last_result", int'(want.last_result),
						int'(got.last_result));
				end
			end
			if (parents.valid && parents.ready) begin
				pair = parents.data;
				if (pairs_held < MAX_CITIES) begin
					tour_a_held[pairs_held] = pair.first_parent_city;
					tour_b_held[pairs_held] = pair.second_parent_city;
					pairs_held++;
				end
				if (pair.last_element)
					predict_children(int'(pair.range_begin), int'(pair.range_end));
			end
		end
		pending <= children_due.size();
	end

endmodule

@@ tb/sv/ordered_crossover_pair_test.sv @@
// Top of the ordered crossover pair testbench: clock, reset, parent loads and output stalls.
// Depends on ocp_pkg, the channel interfaces, the block and ocp_child_compare.
module ordered_crossover_pair_test import ocp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 100;
	localparam int RANDOM_ITEMS = 100;
	localparam int HOLD_CYCLES = 200;
	localparam int HOLD_AFTER = 40;

	typedef enum int {
		LOAD_PERMUTED,
		LOAD_REPEATS,
		LOAD_UNRELATED
	} load_kind_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   words_out;
	int   stall_cycles;

	ocp_in_if  parents();
	ocp_out_if children();

	ordered_crossover_pair dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.parents  (parents),
		.children (children)
	);

	ocp_child_compare child_compare (
		.clk        (clk),
		.arst_n     (arst_n),
		.parents    (parents),
		.children   (children),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
			words_out <= 0;
		end else begin
			if (children.valid && children.ready)
				words_out <= words_out + 1;
			if ((parents.valid && parents.ready) || (children.valid && children.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic mix(ref logic [CITY_W-1:0] q[$]);
		int                j;
		logic [CITY_W-1:0] t;
		for (int i = q.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = q[i];
			q[i] = q[j];
			q[j] = t;
		end
	endtask

	// Offers one parent load; steady loads go out back to back.
	task automatic send_load(input logic [CITY_W-1:0] tour_a[$],
		input logic [CITY_W-1:0] tour_b[$], input int cut_lo, input int cut_hi,
		input bit steady);
		in_word_t w;
		int       gap;
		int       r;
		for (int i = 0; i < tour_a.size(); i++) begin
			w.first_parent_city = tour_a[i];
			w.second_parent_city = tour_b[i];
			w.last_element = (i == tour_a.size() - 1);
			w.range_begin = w.last_element ? RANGE_W'(cut_lo) : RANGE_W'($urandom_range(0, 32));
			w.range_end = w.last_element ? RANGE_W'(cut_hi) : RANGE_W'($urandom_range(0, 32));
			r = $urandom_range(0, 99);
			if (steady || r < 60)
				gap = 0;
			else if (r < 92)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(6, 20);
			if (gap > 0) begin
				parents.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			parents.valid <= 1'b1;
			parents.data <= w;
			@(posedge clk);
			while (!parents.ready)
				@(posedge clk);
		end
	endtask

	// Output side: random stalls, runs of steady acceptance and one long hold-off.
	initial begin
		int  r;
		bit  held;
		held = 1'b0;
		children.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && words_out >= HOLD_AFTER) begin
				held = 1'b1;
				children.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (r < 10) begin
				children.ready <= 1'b1;
				repeat ($urandom_range(30, 60)) @(posedge clk);
			end else if (r < 70) begin
				children.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (r < 95) begin
				children.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				children.ready <= 1'b0;
				repeat ($urandom_range(6, 25)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [CITY_W-1:0] tour_a[$];
		logic [CITY_W-1:0] tour_b[$];
		logic [CITY_W-1:0] pool[$];
		load_kind_t        kind;
		int                sent;
		int                n;
		int                m;
		int                r;
		int                lo;
		int                hi;
		arst_n = 1'b0;
		parents.valid = 1'b0;
		parents.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tour_a = '{5'd31};
		tour_b = '{5'd0};
		send_load(tour_a, tour_b, 0, 1, 1'b1);
		tour_a = '{5'd0, 5'd31, 5'd5};
		tour_b = '{5'd5, 5'd0, 5'd31};
		send_load(tour_a, tour_b, 32, 0, 1'b0);
		tour_a = '{5'd1, 5'd2, 5'd3, 5'd4};
		tour_b = '{5'd4, 5'd3, 5'd2, 5'd1};
		send_load(tour_a, tour_b, 1, 32, 1'b0);
		tour_b = '{5'd2, 5'd1, 5'd2, 5'd1};
		send_load(tour_a, tour_b, 0, 2, 1'b1);
		tour_a = '{5'd10, 5'd21, 5'd16, 5'd8, 5'd31};
		tour_b = '{5'd31, 5'd8, 5'd10, 5'd16, 5'd21};
		send_load(tour_a, tour_b, 3, 3, 1'b0);
		tour_a = '{5'd31, 5'd16, 5'd0};
		tour_b = '{5'd0, 5'd31, 5'd16};
		send_load(tour_a, tour_b, 0, 3, 1'b0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				n = $urandom_range(2, 8);
			else if (r < 85)
				n = $urandom_range(9, 31);
			else if (r < 95)
				n = MAX_CITIES;
			else
				n = $urandom_range(MAX_CITIES + 1, MAX_CITIES + 4);
			m = (n > MAX_CITIES) ? MAX_CITIES : n;
			r = $urandom_range(0, 9);
			kind = (r < 8) ? LOAD_PERMUTED : (r == 8) ? LOAD_REPEATS : LOAD_UNRELATED;
			pool.delete();
			for (int c = 0; c < CITY_SPAN; c++)
				pool.push_back(CITY_W'(c));
			mix(pool);
			tour_a.delete();
			tour_b.delete();
			for (int i = 0; i < m; i++)
				tour_a.push_back(kind == LOAD_REPEATS ? CITY_W'($urandom_range(0, 7)) : pool[i]);
			if (kind == LOAD_UNRELATED) begin
				for (int i = 0; i < m; i++)
					tour_b.push_back(CITY_W'($urandom));
			end else begin
				tour_b = tour_a;
				mix(tour_b);
			end
			for (int i = m; i < n; i++) begin
				tour_a.push_back(CITY_W'($urandom));
				tour_b.push_back(CITY_W'($urandom));
			end
			if ($urandom_range(0, 9) < 7) begin
				lo = $urandom_range(0, m);
				hi = $urandom_range(lo, m);
			end else begin
				lo = $urandom_range(0, 32);
				hi = $urandom_range(0, 32);
			end
			send_load(tour_a, tour_b, lo, hi, $urandom_range(0, 3) == 0);
			sent += n;
		end

		parents.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
